>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the tilt angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held.
`define ACCTILT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds while reset is held.
`define ACCTILT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hdl/acctilt_pkg.sv
// Types, constants and helpers of the accelerometer tilt angle block.
package acctilt_pkg;

    // sample and step counts
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SHIFT_W      = $clog2(TABLE_LEN);
    localparam int SEL_W        = 2;

    // CORDIC datapath
    localparam int GUARD    = 8;
    localparam int MAG_W    = SAMPLE_BITS;
    localparam int GMAG_W   = MAG_W + GUARD;
    localparam int DP_W     = GMAG_W + 4;     // headroom for two CORDIC gains
    localparam int ANG_W    = 19;             // Q16 radians, signed
    localparam int ATAN_W   = 17;

    // gain compensation of the denominator
    localparam int KGAIN    = 107922;
    localparam int KGAIN_W  = 17;
    localparam int KGAIN_SH = 16;
    localparam int KC_W     = MAG_W + KGAIN_W - (KGAIN_SH - GUARD);

    // scale to tenths of a degree: floor(floor(z*90000 / 2^16) / 157)
    localparam int SCALE_MUL   = 90000;
    localparam int SCALE_MUL_W = 17;
    localparam int SCALE_SH    = 16;
    localparam int Q_W         = ANG_W - 1 + SCALE_MUL_W - SCALE_SH;
    localparam int RECIP       = 427445;      // ceil(2^26 / 157)
    localparam int RECIP_W     = 19;
    localparam int RECIP_SH    = 26;
    localparam int DEG_W       = Q_W + RECIP_W - RECIP_SH;

    // result
    localparam int ANGLE_W     = 11;
    localparam int RIGHT_ANGLE = 900;

    // stream packing
    localparam int DATA_IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int DATA_OUT_W = ((ANGLE_W + 7) / 8) * 8;

    localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
        17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
    };

    typedef enum logic [SEL_W-1:0] {
        SEL_Z    = 2'd0,
        SEL_X    = 2'd1,
        SEL_Y    = 2'd2,
        SEL_NONE = 2'd3
    } t_axis_sel;

    typedef enum logic [1:0] {
        MODE_CORDIC,
        MODE_ZERO,
        MODE_INVALID,
        MODE_RIGHT
    } t_mode;

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic [KC_W-1:0]         kc;
        logic                    neg_c;
        t_mode                   mode;
    } t_cordic;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      invalid;
    } t_result;

    function automatic logic [MAG_W-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
        logic signed [SAMPLE_BITS-1:0] neg;
        neg = -v;
        return v[SAMPLE_BITS-1] ? unsigned'(neg) : unsigned'(v);
    endfunction

endpackage

>>> hdl/accel_tilt_angle_unit.sv
// Top level of the accelerometer tilt angle block.
// Takes one x/y/z accelerometer request per cycle plus an axis selector and returns
// the tilt of the selected axis c against the plane of the other two (a, b) as
// atan(sqrt(a^2+b^2)/c) in tenths of a degree, scaled by 1800/3.14 and truncated
// toward zero, range -900..900. Selector 0 measures against z, 1 against x,
// 2 against y; 3 returns 0. A zero denominator with nonzero a/b gives +900;
// all three zero raises the invalid flag with angle 0. Throughput is one request
// per clock while s_tready is high. Pipeline: two front-end stages, one stage per
// CORDIC iteration in each of the two vectoring passes, three scaling stages and
// the output register. Back-pressure freezes the whole pipeline only after the
// single skid entry behind the output register has filled, so s_tready falls in
// the cycle after the first stalled result is taken into the skid entry.
module accel_tilt_angle_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [acctilt_pkg::DATA_IN_W-1:0]   s_tdata,   // [15:0] accel_x, [31:16] accel_y,
                                                           // [47:32] accel_z
    input  logic [acctilt_pkg::SEL_W-1:0]       s_tuser,   // [1:0] axis_select
    // result side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acctilt_pkg::DATA_OUT_W-1:0]  m_tdata,   // [10:0] angle_tenths, rest zero
    output logic                                m_tuser    // [0] invalid
);

    localparam int SB = acctilt_pkg::SAMPLE_BITS;
    localparam int N  = acctilt_pkg::STEPS;

    logic                 en;

    // pass 1: (|a|, |b|) -> K*r in x
    logic                 p1_valid [N+1];
    acctilt_pkg::t_cordic p1_data  [N+1];
    // pass 2: (kc, K*r) -> angle in z
    logic                 p2_valid [N+1];
    acctilt_pkg::t_cordic p2_data  [N+1];

    logic                 res_valid;
    acctilt_pkg::t_result res_data;
    acctilt_pkg::t_result out_data;

    assign s_tready = en;

    acctilt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_tvalid),
        .i_x     ($signed(s_tdata[0*SB +: SB])),
        .i_y     ($signed(s_tdata[1*SB +: SB])),
        .i_z     ($signed(s_tdata[2*SB +: SB])),
        .i_sel   (s_tuser),
        .o_valid (p1_valid[0]),
        .o_data  (p1_data[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_pass1
        acctilt_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (acctilt_pkg::SHIFT_W'(k)),
            .i_valid (p1_valid[k]),
            .i_data  (p1_data[k]),
            .o_valid (p1_valid[k+1]),
            .o_data  (p1_data[k+1])
        );
    end

    // hand-over between passes: x = gain-compensated |c|, y = K*r, fresh angle
    always_comb begin
        p2_valid[0]      = p1_valid[N];
        p2_data[0]       = p1_data[N];
        p2_data[0].x     = $signed(acctilt_pkg::DP_W'(p1_data[N].kc));
        p2_data[0].y     = p1_data[N].x;
        p2_data[0].z     = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_pass2
        acctilt_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (acctilt_pkg::SHIFT_W'(k)),
            .i_valid (p2_valid[k]),
            .i_data  (p2_data[k]),
            .o_valid (p2_valid[k+1]),
            .o_data  (p2_data[k+1])
        );
    end

    acctilt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p2_valid[N]),
        .i_data  (p2_data[N]),
        .o_valid (res_valid),
        .o_data  (res_data)
    );

    acctilt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .o_en    (en),
        .o_valid (m_tvalid),
        .o_data  (out_data),
        .i_ready (m_tready)
    );

    assign m_tdata = {{(acctilt_pkg::DATA_OUT_W - acctilt_pkg::ANGLE_W){1'b0}}, out_data.angle};
    assign m_tuser = out_data.invalid;

endmodule

>>> hdl/acctilt_front.sv
// Front end: axis selection, magnitudes, special cases, gain-compensated denominator.
module acctilt_front (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_valid,
    input  logic signed [acctilt_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic signed [acctilt_pkg::SAMPLE_BITS-1:0] i_y,
    input  logic signed [acctilt_pkg::SAMPLE_BITS-1:0] i_z,
    input  logic [acctilt_pkg::SEL_W-1:0]             i_sel,
    output logic                                      o_valid,
    output acctilt_pkg::t_cordic                      o_data
);

    localparam int PROD_W = acctilt_pkg::MAG_W + acctilt_pkg::KGAIN_W;

    logic signed [acctilt_pkg::SAMPLE_BITS-1:0] a, b, c;
    logic [acctilt_pkg::MAG_W-1:0] r_a_mag, r_b_mag, r_c_mag;
    logic [acctilt_pkg::MAG_W-1:0] n_a_mag, n_b_mag, n_c_mag;
    logic                          r_neg_c, n_neg_c;
    acctilt_pkg::t_mode            r_mode, n_mode;
    logic                          r_valid_a, r_valid_b;
    logic [PROD_W-1:0]             kc_prod;
    acctilt_pkg::t_cordic          r_out, n_out;

    // stage A: pick axes, classify
    always_comb begin
        case (acctilt_pkg::t_axis_sel'(i_sel))
            acctilt_pkg::SEL_Z: begin
                a = i_x; b = i_y; c = i_z;
            end
            acctilt_pkg::SEL_X: begin
                a = i_y; b = i_z; c = i_x;
            end
            default: begin
                a = i_x; b = i_z; c = i_y;
            end
        endcase
        n_a_mag = acctilt_pkg::mag(a);
        n_b_mag = acctilt_pkg::mag(b);
        n_c_mag = acctilt_pkg::mag(c);
        n_neg_c = c[acctilt_pkg::SAMPLE_BITS-1];
        if (acctilt_pkg::t_axis_sel'(i_sel) == acctilt_pkg::SEL_NONE) begin
            n_mode = acctilt_pkg::MODE_ZERO;
        end else if (a == '0 && b == '0 && c == '0) begin
            n_mode = acctilt_pkg::MODE_INVALID;
        end else if (a == '0 && b == '0) begin
            n_mode = acctilt_pkg::MODE_ZERO;
        end else if (c == '0) begin
            n_mode = acctilt_pkg::MODE_RIGHT;
        end else begin
            n_mode = acctilt_pkg::MODE_CORDIC;
        end
    end

    // stage B: guard shift, kc = |c| * K >> (16 - guard)
    always_comb begin
        kc_prod = PROD_W'(r_c_mag) * PROD_W'(acctilt_pkg::KGAIN);
        n_out.x = $signed(acctilt_pkg::DP_W'({r_a_mag, {acctilt_pkg::GUARD{1'b0}}}));
        n_out.y = $signed(acctilt_pkg::DP_W'({r_b_mag, {acctilt_pkg::GUARD{1'b0}}}));
        n_out.z = '0;
        n_out.kc = kc_prod[acctilt_pkg::KGAIN_SH - acctilt_pkg::GUARD +: acctilt_pkg::KC_W];
        n_out.neg_c = r_neg_c;
        n_out.mode = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= n_a_mag;
            r_b_mag <= n_b_mag;
            r_c_mag <= n_c_mag;
            r_neg_c <= n_neg_c;
            r_mode  <= n_mode;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_out;

endmodule

>>> hdl/acctilt_cordic_stage.sv
// One vectoring CORDIC iteration, registered.
module acctilt_cordic_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [acctilt_pkg::SHIFT_W-1:0]   i_shift,
    input  logic                              i_valid,
    input  acctilt_pkg::t_cordic              i_data,
    output logic                              o_valid,
    output acctilt_pkg::t_cordic              o_data
);

    logic signed [acctilt_pkg::DP_W-1:0]  x, y, dx, dy;
    logic signed [acctilt_pkg::ANG_W-1:0] z, at;
    acctilt_pkg::t_cordic                 n_data, r_data;
    logic                                 r_valid;

    always_comb begin
        x  = i_data.x;
        y  = i_data.y;
        z  = i_data.z;
        dx = y >>> i_shift;
        dy = x >>> i_shift;
        at = $signed(acctilt_pkg::ANG_W'(acctilt_pkg::ATAN_TABLE[i_shift]));
        n_data = i_data;
        // rotate toward y == 0; y == 0 takes the negative direction
        if (y > 0) begin
            n_data.x = x + dx;
            n_data.y = y - dy;
            n_data.z = z + at;
        end else begin
            n_data.x = x - dx;
            n_data.y = y + dy;
            n_data.z = z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/acctilt_scale.sv
// Angle scaling to tenths of a degree, clamping, sign and special-case override.
module acctilt_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  acctilt_pkg::t_cordic i_data,
    output logic                 o_valid,
    output acctilt_pkg::t_result o_data
);

    localparam int ZM_W  = acctilt_pkg::ANG_W - 1;
    localparam int P1_W  = ZM_W + acctilt_pkg::SCALE_MUL_W;
    localparam int P2_W  = acctilt_pkg::Q_W + acctilt_pkg::RECIP_W;
    localparam int MAG_W = acctilt_pkg::ANGLE_W - 1;

    logic [ZM_W-1:0]                  zc;
    logic [P1_W-1:0]                  prod1;
    logic [P2_W-1:0]                  prod2;
    logic [acctilt_pkg::Q_W-1:0]      r_q;
    logic [acctilt_pkg::DEG_W-1:0]    r_deg, n_deg;
    logic [MAG_W-1:0]                 deg_mag;
    logic signed [acctilt_pkg::ANGLE_W-1:0] signed_deg;
    logic                             r_neg_c, r_neg_d;
    acctilt_pkg::t_mode               r_mode_c, r_mode_d;
    logic                             r_valid_c, r_valid_d, r_valid_e;
    acctilt_pkg::t_result             r_res, n_res;

    // stage C: clamp at zero, q = z * 90000 >> 16
    always_comb begin
        zc    = i_data.z[acctilt_pkg::ANG_W-1] ? '0 : i_data.z[ZM_W-1:0];
        prod1 = P1_W'(zc) * P1_W'(acctilt_pkg::SCALE_MUL);
    end

    // stage D: q / 157 by reciprocal
    always_comb begin
        prod2 = P2_W'(r_q) * P2_W'(acctilt_pkg::RECIP);
        n_deg = prod2[acctilt_pkg::RECIP_SH +: acctilt_pkg::DEG_W];
    end

    // stage E: clamp, sign, special cases
    always_comb begin
        deg_mag = (r_deg > acctilt_pkg::DEG_W'(acctilt_pkg::RIGHT_ANGLE))
                ? MAG_W'(acctilt_pkg::RIGHT_ANGLE) : r_deg[MAG_W-1:0];
        signed_deg = r_neg_d ? -$signed({1'b0, deg_mag}) : $signed({1'b0, deg_mag});
        case (r_mode_d)
            acctilt_pkg::MODE_CORDIC: begin
                n_res.angle   = signed_deg;
                n_res.invalid = 1'b0;
            end
            acctilt_pkg::MODE_INVALID: begin
                n_res.angle   = '0;
                n_res.invalid = 1'b1;
            end
            acctilt_pkg::MODE_RIGHT: begin
                n_res.angle   = acctilt_pkg::ANGLE_W'(acctilt_pkg::RIGHT_ANGLE);
                n_res.invalid = 1'b0;
            end
            default: begin
                n_res.angle   = '0;
                n_res.invalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
            r_valid_e <= 1'b0;
        end else if (i_en) begin
            r_valid_c <= i_valid;
            r_valid_d <= r_valid_c;
            r_valid_e <= r_valid_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q      <= prod1[acctilt_pkg::SCALE_SH +: acctilt_pkg::Q_W];
            r_neg_c  <= i_data.neg_c;
            r_mode_c <= i_data.mode;
            r_deg    <= n_deg;
            r_neg_d  <= r_neg_c;
            r_mode_d <= r_mode_c;
            r_res    <= n_res;
        end
    end

    assign o_valid = r_valid_e;
    assign o_data  = r_res;

endmodule

>>> hdl/acctilt_outbuf.sv
// Output register with one skid entry; freezes the pipeline only when the skid entry is full.
module acctilt_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  acctilt_pkg::t_result i_data,
    output logic                 o_en,
    output logic                 o_valid,
    output acctilt_pkg::t_result o_data,
    input  logic                 i_ready
);

    logic                 r_out_valid, r_skid_valid;
    acctilt_pkg::t_result r_out, r_skid;
    logic                 hold;

    assign hold = r_out_valid && !i_ready;
    assign o_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (hold) begin
            if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold) begin
            if (!r_skid_valid) begin
                r_skid <= i_data;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hdl/acctilt_chk.sv
// Port-level checker of the tilt angle block and its bind.
`include "assert_macros.svh"

module acctilt_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [acctilt_pkg::DATA_OUT_W-1:0]  m_tdata,
    input logic                                m_tuser
);

    localparam logic signed [acctilt_pkg::ANGLE_W-1:0] MAX_ANGLE =
        acctilt_pkg::ANGLE_W'(acctilt_pkg::RIGHT_ANGLE);

    logic signed [acctilt_pkg::ANGLE_W-1:0] angle;
    assign angle = $signed(m_tdata[acctilt_pkg::ANGLE_W-1:0]);

    `ACCTILT_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_tvalid, "result valid after reset")

    `ACCTILT_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ACCTILT_ASSERT(a_angle_range, i_clk, i_rst_n, m_tvalid |-> angle <= MAX_ANGLE && angle >= -MAX_ANGLE, "angle out of range")

    `ACCTILT_ASSERT(a_invalid_zero, i_clk, i_rst_n, m_tvalid && m_tuser |-> angle == '0, "invalid result with nonzero angle")

endmodule

bind accel_tilt_angle_unit acctilt_chk u_acctilt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/tb_accel_tilt_angle_unit.sv
// Self-checking testbench of the accelerometer tilt angle unit.
module tb_accel_tilt_angle_unit;
    import acctilt_pkg::*;

    localparam int  RANDOM_ITEMS = 1800;
    localparam int  CHUNK        = 100;
    localparam int  DRAIN_CYCLES = 2 * CORDIC_STEPS + 20;   // pipeline depth plus margin
    localparam longint DEG_DIV   = 157 * 65536;             // 1.57 in hundredths, Q16

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata  = '0;    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    logic [SEL_W-1:0]      s_tuser  = '0;    // [1:0] axis_select
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [DATA_OUT_W-1:0] m_tdata;          // [10:0] angle_tenths
    logic                  m_tuser;          // [0] invalid

    // idling controls, changed per test phase
    bit tx_idles  = 1'b1;
    bit rx_stalls = 1'b1;

    t_result expected_tilts[$];
    int      mismatch_count = 0;
    int      rx_hold = 0;

    accel_tilt_angle_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop: well beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // vectoring CORDIC: drives y toward zero, returns final x, accumulates Q16 angle
    function automatic longint cordic_vector(input longint vx, input longint vy,
                                             inout longint turn);
        longint dx, dy;
        for (int i = 0; i < STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx   = vx + dx;
                vy   = vy - dy;
                turn = turn + longint'(ATAN_TABLE[i]);
            end else begin
                vx   = vx - dx;
                vy   = vy + dy;
                turn = turn - longint'(ATAN_TABLE[i]);
            end
        end
        return vx;
    endfunction

    function automatic t_result predict_tilt(input logic signed [SAMPLE_BITS-1:0] ax,
                                             input logic signed [SAMPLE_BITS-1:0] ay,
                                             input logic signed [SAMPLE_BITS-1:0] az,
                                             input t_axis_sel sel);
        longint  a, b, c, abs_a, abs_b, abs_c, kr, kc, turn, scratch, deg;
        t_result res;
        res.angle   = '0;
        res.invalid = 1'b0;
        case (sel)
            SEL_Z: begin
                a = longint'(ax); b = longint'(ay); c = longint'(az);
            end
            SEL_X: begin
                a = longint'(ay); b = longint'(az); c = longint'(ax);
            end
            default: begin
                a = longint'(ax); b = longint'(az); c = longint'(ay);
            end
        endcase
        if (sel == SEL_NONE)
            return res;
        abs_a = (a < 0) ? -a : a;
        abs_b = (b < 0) ? -b : b;
        abs_c = (c < 0) ? -c : c;
        if (a == 0 && b == 0) begin
            // flat against the selected axis; undefined if that axis is zero too
            res.invalid = (c == 0);
            return res;
        end
        if (c == 0) begin
            res.angle = ANGLE_W'(RIGHT_ANGLE);
            return res;
        end
        scratch = 0;
        turn    = 0;
        kr = cordic_vector(abs_a <<< GUARD, abs_b <<< GUARD, scratch);
        kc = ((abs_c <<< GUARD) * KGAIN) >>> 16;
        void'(cordic_vector(kc, kr, turn));
        if (turn < 0)
            turn = 0;
        deg = (turn * 90000) / DEG_DIV;
        if (deg > longint'(RIGHT_ANGLE))
            deg = longint'(RIGHT_ANGLE);
        if (c < 0)
            deg = -deg;
        res.angle = deg[ANGLE_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and result receiver
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!tx_idles || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic send_request(input logic signed [SAMPLE_BITS-1:0] ax,
                                input logic signed [SAMPLE_BITS-1:0] ay,
                                input logic signed [SAMPLE_BITS-1:0] az,
                                input t_axis_sel sel);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        s_tuser  <= sel;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // back-pressure: mostly ready, short stalls, the odd long one
    always @(negedge i_clk) begin : rx_drive
        int unsigned r;
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
        end
    end

    task automatic log_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected angle %0d invalid %0b, got angle %0d invalid %0b",
                     what, want.angle, want.invalid, got.angle, got.invalid);
    endtask

    // compare each result with the oldest prediction; predict each accepted request
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.angle   = m_tdata[ANGLE_W-1:0];
            got.invalid = m_tuser;
            if (expected_tilts.size() == 0) begin
                want = '0;
                log_mismatch("unexpected result", want, got);
            end else begin
                want = expected_tilts.pop_front();
                if (got.angle !== want.angle)
                    log_mismatch("angle", want, got);
                else if (got.invalid !== want.invalid)
                    log_mismatch("invalid", want, got);
            end
        end
        if (i_rst_n && s_tvalid && s_tready)
            expected_tilts.push_back(predict_tilt(s_tdata[15:0], s_tdata[31:16],
                                                  s_tdata[47:32], t_axis_sel'(s_tuser)));
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // full-scale samples on every measuring axis
    task automatic test_axis_extremes();
        t_axis_sel sel;
        for (int k = 0; k < 3; k++) begin
            sel = t_axis_sel'(k);
            send_request(-16'sd32768, -16'sd32768, -16'sd32768, sel);
            send_request(16'sd32767, 16'sd32767, 16'sd32767, sel);
            send_request(-16'sd32768, 16'sd32767, -16'sd1, sel);
        end
        send_request(16'sd1, 16'sd0, -16'sd32768, SEL_Z);   // tiny negative tilt
    endtask

    task automatic test_special_cases();
        // zero denominator, nonzero magnitude -> right angle
        send_request(16'sd5, -16'sd7, 16'sd0, SEL_Z);
        send_request(16'sd0, 16'sd3, -16'sd4, SEL_X);
        send_request(-16'sd32768, 16'sd0, 16'sd1, SEL_Y);
        // zero magnitude, nonzero denominator -> flat
        send_request(16'sd0, 16'sd0, -16'sd9, SEL_Z);
        send_request(16'sd32767, 16'sd0, 16'sd0, SEL_X);
        send_request(16'sd0, -16'sd32768, 16'sd0, SEL_Y);
        // all zero -> invalid
        send_request(16'sd0, 16'sd0, 16'sd0, SEL_Z);
        send_request(16'sd0, 16'sd0, 16'sd0, SEL_X);
        send_request(16'sd0, 16'sd0, 16'sd0, SEL_Y);
        // no axis selected
        send_request(-16'sd32768, 16'sd32767, 16'sd0, SEL_NONE);
        send_request(16'sd0, 16'sd0, 16'sd0, SEL_NONE);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return SAMPLE_BITS'($urandom());
        if (r < 65)
            return SAMPLE_BITS'($signed($urandom_range(0, 40)) - 20);
        if (r < 75)
            return '0;
        if (r < 85)
            case ($urandom_range(0, 4))
                0:       return -16'sd32768;
                1:       return -16'sd32767;
                2:       return -16'sd1;
                3:       return 16'sd1;
                default: return 16'sd32767;
            endcase
        return SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    // random samples in phases that cycle through the idling patterns
    task automatic test_random_samples();
        t_axis_sel sel;
        int        r;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % CHUNK == 0) begin
                tx_idles  = ((n / CHUNK) % 4) inside {0, 2};
                rx_stalls = ((n / CHUNK) % 4) inside {0, 3};
            end
            r   = $urandom_range(0, 9);
            sel = (r == 9) ? SEL_NONE : t_axis_sel'(r % 3);
            send_request(random_sample(), random_sample(), random_sample(), sel);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_axis_extremes();
        test_special_cases();
        test_random_samples();

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        rx_stalls = 1'b1;
        while (expected_tilts.size() != 0)
            @(posedge i_clk);
        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tilts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/acctilt_pkg.sv
hdl/acctilt_front.sv
hdl/acctilt_cordic_stage.sv
hdl/acctilt_scale.sv
hdl/acctilt_outbuf.sv
hdl/accel_tilt_angle_unit.sv
hdl/acctilt_chk.sv
verif/tb_accel_tilt_angle_unit.sv
